[sv/iadt_pkg.sv]
// ---------------------------------------------------------------------------
// iadt_pkg
// Shared types and codes for the anti-diagonal transpose frame buffer.
// ---------------------------------------------------------------------------
package iadt_pkg;

  localparam int CFG_W     = 8;   // widest configuration register
  localparam int CFG_IDX_W = 2;
  localparam int CHAN_W    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // one stored pixel, channel 0 in the low byte
  typedef struct packed {
    logic [CHAN_W-1:0] c2;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c0;
  } pixel_t;

endpackage

[sv/image_anti_diagonal_transpose_unit.sv]
// ---------------------------------------------------------------------------
// image_anti_diagonal_transpose_unit
// Loads a source frame in row-major order and returns it mirrored about the
// anti-diagonal. One item is accepted per clock when in_stall is low, loads
// and reads alike; each item makes at most one access to the single-port
// frame store, which sets that rate. A read result passes the read stage and
// then the output register. The frame store needs no clearing after reset;
// pixels are only read once the whole frame has been loaded. Stall on the
// result side holds up to two results before the input is stalled.
// ---------------------------------------------------------------------------
module image_anti_diagonal_transpose_unit #(
  parameter int MAX_DIM = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [iadt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iadt_pkg::CFG_W-1:0]     cfg_data,
  // input items
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [iadt_pkg::CHAN_W-1:0]    in_chan_zero,
  input  logic [iadt_pkg::CHAN_W-1:0]    in_chan_one,
  input  logic [iadt_pkg::CHAN_W-1:0]    in_chan_two,
  // result items
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [iadt_pkg::CHAN_W-1:0]    out_zero,
  output logic [iadt_pkg::CHAN_W-1:0]    out_one,
  output logic [iadt_pkg::CHAN_W-1:0]    out_two,
  output logic                           out_last_pixel,
  output logic                           out_not_ready
);

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int EXT_W       = (DIM_W > iadt_pkg::CFG_W) ? DIM_W : iadt_pkg::CFG_W;
  localparam int SIZE_W      = 2 * DIM_W;
  localparam int PROD_W      = IDX_W + DIM_W;

  // configuration registers
  logic [iadt_pkg::CFG_W-1:0] cfg_width_r;
  logic [iadt_pkg::CFG_W-1:0] cfg_height_r;
  logic                       cfg_color_r;

  // frame state
  logic [CNT_W-1:0] load_count_r, load_count_nxt;
  logic [IDX_W-1:0] out_row_r, out_row_nxt;
  logic [IDX_W-1:0] out_col_r, out_col_nxt;

  // read stage
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_not_ready_r;
  logic              s1_last_r;
  logic              s1_color_r;
  iadt_pkg::pixel_t  rd_data_r;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [iadt_pkg::CHAN_W-1:0] out_zero_r, out_one_r, out_two_r;
  logic                        out_last_r, out_nr_r;

  iadt_pkg::pixel_t frame_mem [STORE_DEPTH];

  // effective dimensions
  logic [EXT_W-1:0]  width_ext, height_ext;
  logic [DIM_W-1:0]  eff_w, eff_h, w_m1, h_m1;
  logic [SIZE_W-1:0] frame_size;
  logic              frame_full;

  logic [IDX_W-1:0]  cur_i, cur_j, row_off, col_off;
  logic [PROD_W-1:0] row_base, rd_sum;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              pix_last;

  logic adv_out, in_fire, do_load, do_read, mem_read;
  iadt_pkg::pixel_t  wr_pixel;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= iadt_pkg::CFG_W'(128);
      cfg_height_r <= iadt_pkg::CFG_W'(128);
      cfg_color_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        iadt_pkg::CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data;
        iadt_pkg::CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_data;
        iadt_pkg::CFG_COLOR_MODE:   cfg_color_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as MAX_DIM
  always_comb begin
    width_ext  = EXT_W'(cfg_width_r);
    height_ext = EXT_W'(cfg_height_r);
    if (width_ext == '0)
      eff_w = DIM_W'(1);
    else if (width_ext > EXT_W'(MAX_DIM))
      eff_w = DIM_W'(MAX_DIM);
    else
      eff_w = DIM_W'(width_ext);
    if (height_ext == '0)
      eff_h = DIM_W'(1);
    else if (height_ext > EXT_W'(MAX_DIM))
      eff_h = DIM_W'(MAX_DIM);
    else
      eff_h = DIM_W'(height_ext);
  end

  assign w_m1       = eff_w - DIM_W'(1);
  assign h_m1       = eff_h - DIM_W'(1);
  assign frame_size = SIZE_W'(eff_w) * SIZE_W'(eff_h);
  assign frame_full = SIZE_W'(load_count_r) >= frame_size;

  // ---------------------------------------------------------------------------
  // read address: output (i, j) comes from source (h-1-j, w-1-i)
  // ---------------------------------------------------------------------------
  always_comb begin
    cur_i = (DIM_W'(out_row_r) >= eff_w) ? IDX_W'(w_m1) : out_row_r;
    cur_j = (DIM_W'(out_col_r) >= eff_h) ? IDX_W'(h_m1) : out_col_r;
  end

  assign row_off  = IDX_W'(h_m1) - cur_j;
  assign col_off  = IDX_W'(w_m1) - cur_i;
  assign row_base = PROD_W'(row_off) * PROD_W'(eff_w);
  assign rd_sum   = row_base + PROD_W'(col_off);
  assign rd_addr  = ADDR_W'(rd_sum);
  assign wr_addr  = load_count_r[ADDR_W-1:0];
  assign pix_last = (cur_i == IDX_W'(w_m1)) && (cur_j == IDX_W'(h_m1));

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  assign adv_out  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv_out;
  assign in_fire  = in_valid && !in_stall;
  assign do_load  = in_fire && (in_action == iadt_pkg::ACT_LOAD) && !frame_full;
  assign do_read  = in_fire && (in_action == iadt_pkg::ACT_READ);
  assign mem_read = do_read && frame_full;

  always_comb begin
    wr_pixel.c0 = in_chan_zero;
    wr_pixel.c1 = cfg_color_r ? in_chan_one : '0;
    wr_pixel.c2 = cfg_color_r ? in_chan_two : '0;
  end

  // ---------------------------------------------------------------------------
  // frame state update
  // ---------------------------------------------------------------------------
  always_comb begin
    load_count_nxt = load_count_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    if (do_load) begin
      load_count_nxt = CNT_W'(load_count_r + 1'b1);
    end else if (mem_read) begin
      if (pix_last) begin
        load_count_nxt = '0;
        out_row_nxt    = '0;
        out_col_nxt    = '0;
      end else if (cur_j == IDX_W'(h_m1)) begin
        out_col_nxt = '0;
        out_row_nxt = IDX_W'(cur_i + 1'b1);
      end else begin
        out_col_nxt = IDX_W'(cur_j + 1'b1);
        out_row_nxt = cur_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
    end else begin
      load_count_r <= load_count_nxt;
      out_row_r    <= out_row_nxt;
      out_col_r    <= out_col_nxt;
    end
  end

  // frame store, at most one access per item
  always_ff @(posedge clk) begin
    if (do_load)
      frame_mem[wr_addr] <= wr_pixel;
    if (mem_read)
      rd_data_r <= frame_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // read stage and output register
  // ---------------------------------------------------------------------------
  always_comb begin
    if (do_read)
      s1_valid_nxt = 1'b1;
    else if (adv_out)
      s1_valid_nxt = 1'b0;
    else
      s1_valid_nxt = s1_valid_r;
    out_valid_nxt = adv_out ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      s1_not_ready_r <= !frame_full;
      s1_last_r      <= frame_full && pix_last;
      s1_color_r     <= cfg_color_r;
    end
    if (adv_out && s1_valid_r) begin
      out_zero_r <= s1_not_ready_r ? '0 : rd_data_r.c0;
      out_one_r  <= (s1_not_ready_r || !s1_color_r) ? '0 : rd_data_r.c1;
      out_two_r  <= (s1_not_ready_r || !s1_color_r) ? '0 : rd_data_r.c2;
      out_last_r <= s1_last_r;
      out_nr_r   <= s1_not_ready_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_zero       = out_zero_r;
  assign out_one        = out_one_r;
  assign out_two        = out_two_r;
  assign out_last_pixel = out_last_r;
  assign out_not_ready  = out_nr_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_read && pix_last) |=> (load_count_r == '0 && out_row_r == '0 && out_col_r == '0))
    else $error("frame state not cleared after last pixel");

  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with room in the pipe");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_not_ready) |->
      (out_zero == '0 && out_one == '0 && out_two == '0 && !out_last_pixel))
    else $error("not-ready result carries data");

  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv_out && !do_read) |=> (!s1_valid_r && out_valid_r))
    else $error("read stage item lost");

endmodule

[tb/mirror_check_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mirror_check_pkg
// Prediction and checking for the anti-diagonal transpose frame buffer. Keeps
// its own copy of the frame store, load and output counters and the three
// registers. It works out each mirrored pixel as a read item is accepted and
// compares the results field by field, in order.
// ---------------------------------------------------------------------------
package mirror_check_pkg;

  localparam int MIRROR_MAX_DIM = 128;

  typedef struct packed {
    logic [iadt_pkg::CHAN_W-1:0] zero;
    logic [iadt_pkg::CHAN_W-1:0] one;
    logic [iadt_pkg::CHAN_W-1:0] two;
    logic                        last_pixel;
    logic                        not_ready;
  } mirror_result_t;

  class mirror_scoreboard;
    iadt_pkg::pixel_t frame_copy [MIRROR_MAX_DIM*MIRROR_MAX_DIM];
    int unsigned      loaded;
    int unsigned      row_ptr;
    int unsigned      col_ptr;
    logic [7:0]       width_reg;
    logic [7:0]       height_reg;
    logic             color_reg;
    mirror_result_t   mirrored_px_q [$];
    int               errors;
    int               frames_done;
    int               pixels_out;
    int               early_reads;

    function new();
      width_reg   = 8'd128;
      height_reg  = 8'd128;
      color_reg   = 1'b1;
      loaded      = 0;
      row_ptr     = 0;
      col_ptr     = 0;
      errors      = 0;
      frames_done = 0;
      pixels_out  = 0;
      early_reads = 0;
    endfunction

    // 0 acts as 1, anything past MIRROR_MAX_DIM acts as the max
    function int unsigned eff_dim(logic [7:0] v);
      if (v == 8'd0) return 1;
      if (v > MIRROR_MAX_DIM) return MIRROR_MAX_DIM;
      return 32'(v);
    endfunction

    function void write_reg(logic [iadt_pkg::CFG_IDX_W-1:0] idx,
                            logic [iadt_pkg::CFG_W-1:0] data);
      case (idx)
        iadt_pkg::CFG_IMAGE_WIDTH: width_reg = data;
        iadt_pkg::CFG_IMAGE_HEIGHT: height_reg = data;
        iadt_pkg::CFG_COLOR_MODE: color_reg = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return mirrored_px_q.size();
    endfunction

    // returns 0 for a surplus load, which the block ignores
    function bit accept_item(logic act, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
      int unsigned      w;
      int unsigned      h;
      int unsigned      i;
      int unsigned      j;
      int unsigned      addr;
      iadt_pkg::pixel_t px;
      mirror_result_t   r;
      w = eff_dim(width_reg);
      h = eff_dim(height_reg);
      if (act == iadt_pkg::ACT_LOAD) begin
        if (loaded >= w * h) return 0;
        px.c0 = c0;
        px.c1 = color_reg ? c1 : 8'h00;
        px.c2 = color_reg ? c2 : 8'h00;
        frame_copy[loaded] = px;
        loaded++;
        return 1;
      end
      r = '0;
      if (loaded < w * h) begin
        r.not_ready = 1'b1;
        mirrored_px_q.push_back(r);
        early_reads++;
        return 1;
      end
      // output image is h wide and w high; stale counters clamp to the bound
      i = (row_ptr >= w) ? w - 1 : row_ptr;
      j = (col_ptr >= h) ? h - 1 : col_ptr;
      addr = (h - 1 - j) * w + (w - 1 - i);
      px = frame_copy[addr];
      r.zero       = px.c0;
      r.one        = color_reg ? px.c1 : 8'h00;
      r.two        = color_reg ? px.c2 : 8'h00;
      r.last_pixel = (i + 1 >= w) && (j + 1 >= h);
      mirrored_px_q.push_back(r);
      pixels_out++;
      if (r.last_pixel) begin
        loaded  = 0;
        row_ptr = 0;
        col_ptr = 0;
        frames_done++;
      end else if (j + 1 >= h) begin
        col_ptr = 0;
        row_ptr = i + 1;
      end else begin
        col_ptr = j + 1;
        row_ptr = i;
      end
      return 1;
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_pixel(logic [7:0] zero, logic [7:0] one, logic [7:0] two,
                              logic last_pixel, logic not_ready);
      mirror_result_t e;
      if (mirrored_px_q.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h %0h %0h last=%0b nr=%0b",
                 $time, zero, one, two, last_pixel, not_ready);
        errors++;
        return;
      end
      e = mirrored_px_q.pop_front();
      compare_field("out_zero", e.zero, zero);
      compare_field("out_one", e.one, one);
      compare_field("out_two", e.two, two);
      compare_field("out_last_pixel", {7'd0, e.last_pixel}, {7'd0, last_pixel});
      compare_field("out_not_ready", {7'd0, e.not_ready}, {7'd0, not_ready});
    endfunction
  endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Testbench for image_anti_diagonal_transpose_unit. A short directed part
// covers channel extremes, early reads, surplus loads, grey mode, a zero
// dimension and a size change in the middle of read-out; then random frames
// of many sizes, mostly well formed with some noise, run under random gaps
// and output stalls.
// ---------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TARGET_ITEMS   = 1800;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CFG_SETTLE     = 4;

  logic                           clk          = 1'b0;
  logic                           rst_n        = 1'b0;
  logic                           cfg_we       = 1'b0;
  logic [iadt_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
  logic [iadt_pkg::CFG_W-1:0]     cfg_data     = '0;
  logic                           in_valid     = 1'b0;
  logic                           in_stall;
  logic                           in_action    = iadt_pkg::ACT_LOAD;
  logic [iadt_pkg::CHAN_W-1:0]    in_chan_zero = '0;
  logic [iadt_pkg::CHAN_W-1:0]    in_chan_one  = '0;
  logic [iadt_pkg::CHAN_W-1:0]    in_chan_two  = '0;
  logic                           out_valid;
  logic                           out_stall    = 1'b0;
  logic [iadt_pkg::CHAN_W-1:0]    out_zero;
  logic [iadt_pkg::CHAN_W-1:0]    out_one;
  logic [iadt_pkg::CHAN_W-1:0]    out_two;
  logic                           out_last_pixel;
  logic                           out_not_ready;

  mirror_check_pkg::mirror_scoreboard sb;
  int               useful_items = 0;
  int               phases       = 0;
  int               idle_cycles  = 0;
  int               stall_left   = 0;
  int unsigned      stall_roll;
  logic             stall_next;
  logic             quiet        = 1'b0;

  image_anti_diagonal_transpose_unit #(
    .MAX_DIM(mirror_check_pkg::MIRROR_MAX_DIM)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_chan_zero  (in_chan_zero),
    .in_chan_one   (in_chan_one),
    .in_chan_two   (in_chan_two),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_zero      (out_zero),
    .out_one       (out_one),
    .out_two       (out_two),
    .out_last_pixel(out_last_pixel),
    .out_not_ready (out_not_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side back-pressure: mostly short bursts, a few long ones
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      stall_next = 1'b1;
    end else if (quiet) begin
      stall_next = 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        stall_next = 1'b0;
      end else if (stall_roll < 96) begin
        stall_left = $urandom_range(0, 3);
        stall_next = 1'b1;
      end else begin
        stall_left = $urandom_range(10, 60);
        stall_next = 1'b1;
      end
    end
    out_stall <= stall_next;
  end

  // monitors and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (sb.accept_item(in_action, in_chan_zero, in_chan_one, in_chan_two))
          useful_items++;
      end
      if (out_valid && !out_stall)
        sb.check_pixel(out_zero, out_one, out_two, out_last_pixel, out_not_ready);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results still expected", $time, sb.pending());
        $display("[image_anti_diagonal_transpose_unit] ERROR");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(logic act, logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_chan_zero <= c0;
    in_chan_one  <= c1;
    in_chan_two  <= c2;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_load();
    send_item(iadt_pkg::ACT_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  // channel bits are don't-care on reads, so toggle them anyway
  task automatic send_read();
    send_item(iadt_pkg::ACT_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(logic [iadt_pkg::CFG_IDX_W-1:0] idx,
                           logic [iadt_pkg::CFG_W-1:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(logic [7:0] w, logic [7:0] h, logic color);
    write_reg(iadt_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(iadt_pkg::CFG_IMAGE_HEIGHT, h);
    write_reg(iadt_pkg::CFG_COLOR_MODE, {7'd0, color});
    phases++;
    quiet <= ($urandom_range(0, 3) == 0);
  endtask

  // full frame in, full frame out, with the odd early read or surplus load
  task automatic run_frame(int unsigned size);
    int unsigned n;
    for (n = 0; n < size; n++) begin
      if ($urandom_range(0, 24) == 0) send_read();
      send_load();
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_load();
    for (n = 0; n < size; n++) send_read();
    if ($urandom_range(0, 9) == 0) send_read();
  endtask

  task automatic run_noise(int unsigned size);
    int unsigned n;
    n = $urandom_range(1, 2 * size + 4);
    repeat (n) begin
      if ($urandom_range(0, 1)) send_load();
      else send_read();
    end
  endtask

  task automatic random_phase(int k);
    logic [7:0]  w;
    logic [7:0]  h;
    int unsigned r;
    int unsigned size;
    int unsigned frames;
    r = $urandom_range(0, 11);
    if (k == 0) begin
      w = 8'd255;
      h = 8'd1;
    end else if (k == 1) begin
      w = 8'd1;
      h = 8'd128;
    end else if (k == 2) begin
      w = 8'd128;
      h = 8'd0;
    end else if (r == 0) begin
      w = $urandom_range(0, 1) ? 8'd128 : 8'($urandom_range(100, 255));
      h = 8'($urandom_range(0, 2));
    end else if (r == 1) begin
      w = 8'($urandom_range(0, 2));
      h = $urandom_range(0, 1) ? 8'd128 : 8'($urandom_range(100, 255));
    end else begin
      w = (r == 2) ? 8'd0 : 8'($urandom_range(1, 6));
      h = 8'($urandom_range(1, 6));
    end
    set_frame(w, h, 1'($urandom_range(0, 1)));
    size = sb.eff_dim(w) * sb.eff_dim(h);
    frames = (size > 64) ? 1 : $urandom_range(1, 3);
    repeat (frames) begin
      if ($urandom_range(0, 4) == 0) run_noise(size);
      else run_frame(size);
    end
  endtask

  initial begin
    int k;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x2 color frame: early read, channel extremes, surplus load
    set_frame(8'd3, 8'd2, 1'b1);
    send_item(iadt_pkg::ACT_READ, 8'h00, 8'h00, 8'h00);
    send_item(iadt_pkg::ACT_LOAD, 8'h00, 8'h00, 8'h00);
    send_item(iadt_pkg::ACT_LOAD, 8'hFF, 8'hFF, 8'hFF);
    send_item(iadt_pkg::ACT_LOAD, 8'hA5, 8'h5A, 8'hA5);
    send_item(iadt_pkg::ACT_LOAD, 8'h5A, 8'hA5, 8'h5A);
    send_item(iadt_pkg::ACT_LOAD, 8'h01, 8'h80, 8'h7F);
    send_item(iadt_pkg::ACT_LOAD, 8'hFE, 8'h7F, 8'h80);
    send_item(iadt_pkg::ACT_LOAD, 8'h12, 8'h34, 8'h56);
    repeat (6) send_item(iadt_pkg::ACT_READ, 8'h00, 8'h00, 8'h00);

    // grey mode, zero width acts as one
    set_frame(8'd0, 8'd2, 1'b0);
    send_item(iadt_pkg::ACT_LOAD, 8'hFF, 8'hFF, 8'hFF);
    send_item(iadt_pkg::ACT_LOAD, 8'h3C, 8'hC3, 8'h99);
    repeat (2) send_item(iadt_pkg::ACT_READ, 8'hFF, 8'hFF, 8'hFF);

    // shrink height after the first output pixel
    set_frame(8'd2, 8'd2, 1'b1);
    repeat (4) send_load();
    send_read();
    write_reg(iadt_pkg::CFG_IMAGE_HEIGHT, 8'd1);
    repeat (2) send_read();

    k = 0;
    while (useful_items < TARGET_ITEMS) begin
      random_phase(k);
      k++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d effective items over %0d register settings, %0d frames mirrored",
             useful_items, phases, sb.frames_done);
    $display("%0d pixels read out, %0d early reads flagged not ready",
             sb.pixels_out, sb.early_reads);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[image_anti_diagonal_transpose_unit] OK");
    end else begin
      $display("[image_anti_diagonal_transpose_unit] ERROR");
    end
    $finish;
  end

endmodule
